>>> src/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types and constants of the sliding window median filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

	localparam int CH_W  = 8;
	localparam int PIX_W = 3 * CH_W;

	// pixel word as kept in the line stores and the window: {c, b, a}
	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [CH_W-1:0]  chan_t;

	typedef struct packed {
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
		logic       frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] med_a;
		logic [7:0] med_b;
		logic [7:0] med_c;
		logic       frame_end;
	} pix_out_t;

	typedef enum logic [1:0] {
		REG_WINDOW_SIZE  = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} reg_idx_t;

	localparam logic [2:0]  RST_WINDOW_SIZE  = 3'd4;
	localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;

	// stage controls handed to the rank and select pipeline
	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
		logic v_s4;
	} swmf_ctl_t;

endpackage

>>> src/sliding_window_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// Per-channel K by K median over a raster stream of three-channel pixels.
// ----------------------------------------------------------------------------
// One pixel is taken every clock while pix_ready is high. Each pixel reads its
// column from a single line store memory (one word per column holding the
// MAX_K-1 previous lines), the word is shifted down by one line and written
// back, and a read that meets that write on the same column is bypassed. The
// column enters a MAX_K by MAX_K shift window; the active K by K part is
// ranked by a compare matrix and a popcount, and the sample of rank K*K/2 is
// picked. A result appears only for pixels whose window lies wholly inside
// the frame; the last one of a frame carries frame_end. Configuration goes
// through the APB port (window_size at 0x0, image_width at 0x4, image_height
// at 0x8) while the stream is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module sliding_window_median_filter #(
	parameter int MAX_K     = 5,
	parameter int MAX_WIDTH = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	// pixel beats
	input  logic              pix_valid,
	output logic              pix_ready,
	input  swmf_pkg::pix_in_t pix,
	// result beats
	output logic              med_valid,
	input  logic              med_ready,
	output swmf_pkg::pix_out_t med,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import swmf_pkg::*;

	localparam int N  = MAX_K * MAX_K;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = (MAX_K - 1) * PIX_W;
	localparam int MW = $clog2(N);
	localparam int WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
	localparam int XW = WW + 1;

	// configuration registers
	logic [2:0]  ksize_q;
	logic [11:0] width_q;
	logic [11:0] height_q;
	reg_idx_t    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksize_q  <= RST_WINDOW_SIZE;
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_WINDOW_SIZE:  ksize_q  <= pwdata[2:0];
				REG_IMAGE_WIDTH:  width_q  <= pwdata[11:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_SIZE:  prdata = {29'd0, ksize_q};
			REG_IMAGE_WIDTH:  prdata = {20'd0, width_q};
			REG_IMAGE_HEIGHT: prdata = {20'd0, height_q};
			default:          prdata = '0;
		endcase
	end

	// clamped sizes: out-of-range values fold to the nearest legal one
	logic [2:0]    k_eff;
	logic [XW-1:0] w_eff;
	logic [XW-1:0] h_eff;
	logic [XW-1:0] k_ext;

	always_comb begin
		if (ksize_q == 3'd0)                k_eff = 3'd1;
		else if (ksize_q > 3'(MAX_K))       k_eff = 3'(MAX_K);
		else                                k_eff = ksize_q;
		if (width_q == 12'd0)               w_eff = XW'(1);
		else if (XW'(width_q) > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
		else                                w_eff = XW'(width_q);
		h_eff = (height_q == 12'd0) ? XW'(1) : XW'(height_q);
		k_ext = XW'(k_eff);
	end

	// active window mask (bottom-right K by K) and middle rank
	logic [N-1:0]  act;
	logic [MW-1:0] mid;

	always_comb begin
		for (int y = 0; y < MAX_K; y++) begin
			for (int x = 0; x < MAX_K; x++) begin
				act[y*MAX_K + x] = (y >= MAX_K - int'(k_eff)) && (x >= MAX_K - int'(k_eff));
			end
		end
		mid = MW'((6'(k_eff) * 6'(k_eff)) >> 1);
	end

	// pipeline occupancy, freed from the output end backward
	logic v_s1, v_s2, v_s3, v_s4;
	logic out_free, s4_free, s3_free, s2_free, s1_free;
	logic acc, adv_s1;

	assign out_free  = !med_valid || med_ready;
	assign s4_free   = !v_s4 || out_free;
	assign s3_free   = !v_s3 || s4_free;
	assign s2_free   = !v_s2 || s3_free;
	assign s1_free   = !v_s1 || s2_free;
	assign pix_ready = s1_free;
	assign acc       = pix_valid && pix_ready;
	assign adv_s1    = v_s1 && s2_free;

	// raster position
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic [CW-1:0] c_cur;
	logic [11:0]   r_cur;
	logic [XW-1:0] c_ext, r_ext;
	logic          emit, fend;

	always_comb begin
		c_cur = pix.frame_start ? '0 : col_q;
		r_cur = pix.frame_start ? '0 : row_q;
		c_ext = XW'(c_cur);
		r_ext = XW'(r_cur);
		emit  = (c_ext < w_eff) && (r_ext < h_eff) &&
			(c_ext + XW'(1) >= k_ext) && (r_ext + XW'(1) >= k_ext);
		fend  = (c_ext == w_eff - XW'(1)) && (r_ext == h_eff - XW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (c_ext + XW'(1) >= w_eff) begin
				col_q <= '0;
				row_q <= (r_ext + XW'(1) >= h_eff) ? 12'd0 : 12'(r_ext + XW'(1));
			end else begin
				col_q <= CW'(c_ext + XW'(1));
				row_q <= r_cur;
			end
		end
	end

	// stage 1: column word arrives from the line store
	pixel_t        pix_s1;
	logic [CW-1:0] col_s1;
	logic          emit_s1, fend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= {pix.chan_c, pix.chan_b, pix.chan_a};
			col_s1  <= c_cur;
			emit_s1 <= emit;
			fend_s1 <= fend;
		end
	end

	logic [LW-1:0] lines;
	logic [LW-1:0] lines_new;
	pixel_t        col_vec [MAX_K];

	swmf_line_buf #(
		.DEPTH  (MAX_WIDTH),
		.WORD_W (LW),
		.AW     (CW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (c_cur),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (lines_new),
		.rd_data (lines)
	);

	// cascade: newest pixel into line 0, every older line one further down
	always_comb begin
		lines_new[PIX_W-1:0] = pix_s1;
		for (int d = 1; d < MAX_K - 1; d++) begin
			lines_new[d*PIX_W +: PIX_W] = lines[(d-1)*PIX_W +: PIX_W];
		end
		col_vec[MAX_K-1] = pix_s1;
		for (int d = 1; d < MAX_K; d++) begin
			col_vec[MAX_K-1-d] = lines[(d-1)*PIX_W +: PIX_W];
		end
	end

	// shift window, newest column on the right
	pixel_t win_q [MAX_K][MAX_K];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int y = 0; y < MAX_K; y++) begin
				for (int x = 0; x < MAX_K; x++) begin
					win_q[y][x] <= '0;
				end
			end
		end else if (adv_s1) begin
			for (int y = 0; y < MAX_K; y++) begin
				for (int x = 0; x < MAX_K - 1; x++) begin
					win_q[y][x] <= win_q[y][x+1];
				end
				win_q[y][MAX_K-1] <= col_vec[y];
			end
		end
	end

	// stage 2 holds the window still; stages 3 and 4 rank, then output
	logic fend_s2, fend_s3, fend_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			med_valid <= 1'b0;
		end else begin
			if (s2_free)  v_s2      <= v_s1 && emit_s1;
			if (s3_free)  v_s3      <= v_s2;
			if (s4_free)  v_s4      <= v_s3;
			if (out_free) med_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) fend_s2 <= fend_s1;
		if (s3_free) fend_s3 <= fend_s2;
		if (s4_free) fend_s4 <= fend_s3;
	end

	logic [N-1:0][7:0] va, vb, vc;
	swmf_ctl_t         ctl;
	chan_t             ma, mb, mc;

	always_comb begin
		for (int y = 0; y < MAX_K; y++) begin
			for (int x = 0; x < MAX_K; x++) begin
				va[y*MAX_K + x] = win_q[y][x][7:0];
				vb[y*MAX_K + x] = win_q[y][x][15:8];
				vc[y*MAX_K + x] = win_q[y][x][23:16];
			end
		end
	end

	assign ctl.ld_s3 = s3_free;
	assign ctl.ld_s4 = s4_free;
	assign ctl.v_s4  = v_s4;

	swmf_median #(.N(N), .MW(MW)) u_med_a (
		.clk (clk), .arst_n (arst_n), .ctl (ctl),
		.vals (va), .act (act), .mid (mid), .med (ma)
	);
	swmf_median #(.N(N), .MW(MW)) u_med_b (
		.clk (clk), .arst_n (arst_n), .ctl (ctl),
		.vals (vb), .act (act), .mid (mid), .med (mb)
	);
	swmf_median #(.N(N), .MW(MW)) u_med_c (
		.clk (clk), .arst_n (arst_n), .ctl (ctl),
		.vals (vc), .act (act), .mid (mid), .med (mc)
	);

	// output register
	always_ff @(posedge clk) begin
		if (out_free) begin
			med.med_a     <= ma;
			med.med_b     <= mb;
			med.med_c     <= mc;
			med.frame_end <= fend_s4;
		end
	end

`ifndef ASSERT_OFF
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pix.frame_start && w_eff > XW'(1)) |=> (col_q == CW'(1) && row_q == 12'd0))
		else $error("frame start did not restart the raster position");
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (v_s1 && v_s2))
		else $error("input stalled with a free front stage");
	a_s2_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1 && emit_s1))
		else $error("rank stage loaded without a windowed pixel");
`endif

endmodule

>>> src/swmf_line_buf.sv
// ----------------------------------------------------------------------------
// swmf_line_buf
// Line store memory, one word per column holding all stored lines, with a
// bypass for a read that meets a write to the same column.
// ----------------------------------------------------------------------------
module swmf_line_buf #(
	parameter int DEPTH  = 2048,
	parameter int WORD_W = 96,
	parameter int AW     = 11
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] mem_q;
	logic [WORD_W-1:0] byp_data_q;
	logic              byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	// same column written and read at one edge: take the new word
	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_q      <= wr_en && (wr_addr == rd_addr);
			byp_data_q <= wr_data;
		end
	end

	assign rd_data = byp_q ? byp_data_q : mem_q;

endmodule

>>> src/swmf_median.sv
// ----------------------------------------------------------------------------
// swmf_median
// Rank based median of one channel: a compare matrix, a popcount per sample
// and a one-hot pick of the sample whose rank is the middle index.
// ----------------------------------------------------------------------------
module swmf_median #(
	parameter int N  = 25,
	parameter int MW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swmf_pkg::swmf_ctl_t   ctl,
	input  logic [N-1:0][7:0]     vals,
	input  logic [N-1:0]          act,
	input  logic [MW-1:0]         mid,
	output logic [7:0]            med
);
	import swmf_pkg::*;

	logic [N-1:0][N-1:0] lt_c;
	logic [N-1:0][N-1:0] lt_s3;
	logic [N-1:0][7:0]   val_s3;
	logic [N-1:0]        act_s3;
	logic [N-1:0][MW-1:0] rank_s4;
	logic [N-1:0][7:0]   val_s4;
	logic [N-1:0]        act_s4;
	logic [N-1:0]        hit;

	// sample j sorts ahead of sample i; ties broken by position
	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				lt_c[i][j] = act[j] && ((vals[j] < vals[i]) ||
					((vals[j] == vals[i]) && (j < i)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			lt_s3  <= lt_c;
			val_s3 <= vals;
			act_s3 <= act;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			for (int i = 0; i < N; i++) begin
				rank_s4[i] <= MW'($countones(lt_s3[i]));
			end
			val_s4 <= val_s3;
			act_s4 <= act_s3;
		end
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < N; i++) begin
			hit[i] = act_s4[i] && (rank_s4[i] == mid);
			med    = med | (hit[i] ? val_s4[i] : 8'd0);
		end
	end

`ifndef ASSERT_OFF
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.v_s4 |-> $onehot(hit))
		else $error("median pick is not one-hot");
`endif

endmodule

>>> verif/tb_sliding_window_median_filter.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_median_filter
// Self-checking bench for the per-channel K by K median filter.
// ----------------------------------------------------------------------------
// Pixel beats are queued by the stimulus process and sent by a bursty driver.
// A behavioral model of the line stores, window and counters predicts every
// result beat, and the monitor checks each result field against it.
// Configuration is written over APB between phases, only while the stream is
// idle and every frame is complete.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_filter;
	import swmf_pkg::*;

	localparam int MK      = 5;
	localparam int MW      = 2048;
	localparam int LAT     = 12;
	localparam int LIMIT   = 2000000;
	localparam int N_RAND  = 700;

	logic        clk;
	logic        arst_n;
	logic        pix_valid;
	logic        pix_ready;
	pix_in_t     pix;
	logic        med_valid;
	logic        med_ready;
	pix_out_t    med;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sliding_window_median_filter dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.med_valid(med_valid), .med_ready(med_ready), .med(med),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// pending pixel beats and expected medians
	pix_in_t  pixel_queue[$];
	pix_out_t median_queue[$];
	int       errors;
	int       cycles;
	int       sent;

	// filter state mirror
	logic [23:0] lstore[MK-1][MW];
	logic [23:0] wnd[MK][MK];
	int          col_cnt;
	int          row_cnt;
	int          cfg_k;
	int          cfg_w;
	int          cfg_h;

	// receiver long hold requests
	int hold_req;
	int hold_ack;
	int hold_cnt;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// element n/2 of the ascending sort
	function automatic logic [7:0] pick_rank(logic [7:0] v[MK*MK], int n);
		logic [7:0] s[MK*MK];
		logic [7:0] t;
		s = v;
		for (int i = 1; i < n; i++) begin
			t = s[i];
			for (int j = i; j >= 0; j--) begin
				if (j > 0 && s[j-1] > t) begin
					s[j] = s[j-1];
				end else begin
					s[j] = t;
					break;
				end
			end
		end
		return s[n/2];
	endfunction

	// advance the mirror by one accepted pixel beat
	function automatic void filter_step(pix_in_t p);
		int k, w, h, c, r, n;
		logic [23:0] col[MK];
		logic [23:0] pw;
		logic [7:0] va[MK*MK], vb[MK*MK], vc[MK*MK];
		pix_out_t o;
		k = (cfg_k < 1) ? 1 : (cfg_k > MK) ? MK : cfg_k;
		w = (cfg_w < 1) ? 1 : (cfg_w > MW) ? MW : cfg_w;
		h = (cfg_h < 1) ? 1 : cfg_h;
		if (p.frame_start) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		c = col_cnt;
		r = row_cnt;
		pw = {p.chan_c, p.chan_b, p.chan_a};
		// new column: current pixel at the bottom, older lines above
		col[MK-1] = pw;
		for (int d = 1; d < MK; d++) col[MK-1-d] = lstore[d-1][c];
		for (int d = MK - 1; d > 1; d--) lstore[d-1][c] = lstore[d-2][c];
		lstore[0][c] = pw;
		for (int y = 0; y < MK; y++) begin
			for (int x = 0; x < MK - 1; x++) wnd[y][x] = wnd[y][x+1];
			wnd[y][MK-1] = col[y];
		end
		if (c < w && r < h && c + 1 >= k && r + 1 >= k) begin
			n = 0;
			for (int y = MK - k; y < MK; y++) begin
				for (int x = MK - k; x < MK; x++) begin
					va[n] = wnd[y][x][7:0];
					vb[n] = wnd[y][x][15:8];
					vc[n] = wnd[y][x][23:16];
					n++;
				end
			end
			o.med_a     = pick_rank(va, n);
			o.med_b     = pick_rank(vb, n);
			o.med_c     = pick_rank(vc, n);
			o.frame_end = (c == w - 1 && r == h - 1);
			median_queue = {median_queue, o};
		end
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : ((r + 1) & 12'hfff);
		end else begin
			col_cnt = (c + 1) & 11'h7ff;
		end
	endfunction

	// run-wide watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// driver: bursts of beats separated by random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid  <= 1'b0;
			pix        <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (pix_valid && pix_ready) filter_step(pix);
			if (!pix_valid || pix_ready) begin
				if (gap_left > 0) begin
					gap_left  <= gap_left - 1;
					pix_valid <= 1'b0;
				end else if (pixel_queue.size() > 0) begin
					pix       <= pixel_queue.pop_front();
					pix_valid <= 1'b1;
					sent      <= sent + 1;
					if (burst_left == 0) begin
						// end of burst: pick the next gap and burst length
						burst_left <= $urandom_range(40, 1);
						gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: own stall pattern plus an occasional long hold
	int rx_mode;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			med_ready <= 1'b0;
			rx_mode   <= 0;
			hold_cnt  <= 0;
			hold_ack  <= 0;
		end else begin
			if ($urandom_range(63, 0) == 0) rx_mode <= $urandom_range(2, 0);
			if (hold_ack != hold_req) begin
				hold_ack  <= hold_req;
				hold_cnt  <= 400;
				med_ready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt  <= hold_cnt - 1;
				med_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: med_ready <= 1'b1;
					1: med_ready <= ($urandom_range(3, 0) != 0);
					default: med_ready <= ($urandom_range(3, 0) == 0);
				endcase
			end
		end
	end

	// monitor: every result beat against the oldest expectation
	always @(posedge clk) begin
		pix_out_t e;
		if (arst_n && med_valid && med_ready) begin
			if (median_queue.size() == 0) begin
				$error("unexpected result beat med_a=%0d med_b=%0d med_c=%0d",
					med.med_a, med.med_b, med.med_c);
				errors++;
			end else begin
				e = median_queue.pop_front();
				if (med.med_a !== e.med_a) begin
					$error("med_a expected %0d actual %0d", e.med_a, med.med_a);
					errors++;
				end
				if (med.med_b !== e.med_b) begin
					$error("med_b expected %0d actual %0d", e.med_b, med.med_b);
					errors++;
				end
				if (med.med_c !== e.med_c) begin
					$error("med_c expected %0d actual %0d", e.med_c, med.med_c);
					errors++;
				end
				if (med.frame_end !== e.frame_end) begin
					$error("frame_end expected %0d actual %0d", e.frame_end, med.frame_end);
					errors++;
				end
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, int value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// the register takes the value at this edge
		case (idx)
			REG_WINDOW_SIZE:  cfg_k = value & 7;
			REG_IMAGE_WIDTH:  cfg_w = value & 12'hfff;
			default:          cfg_h = value & 12'hfff;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait until the stream has drained, then let the pipeline settle
	task automatic drain();
		while (pixel_queue.size() > 0 || pix_valid || median_queue.size() > 0)
			@(posedge clk);
		repeat (LAT) @(posedge clk);
	endtask

	task automatic set_size(int k, int w, int h);
		drain();
		reg_write(REG_WINDOW_SIZE, k);
		reg_write(REG_IMAGE_WIDTH, w);
		reg_write(REG_IMAGE_HEIGHT, h);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7, 0))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255, 0));
		endcase
	endfunction

	// queue frames; first pixel opens a frame, noise adds stray frame starts
	// which restart the frame, so the phase still ends on a frame boundary
	task automatic queue_pixels(int w, int h, int frames, bit noise);
		pix_in_t p;
		int pos, done;
		w = (w < 1) ? 1 : (w > MW) ? MW : w;
		h = (h < 1) ? 1 : h;
		pos  = 0;
		done = 0;
		while (done < frames) begin
			p.chan_a      = rand_byte();
			p.chan_b      = rand_byte();
			p.chan_c      = rand_byte();
			p.frame_start = (pixel_queue.size() == 0 && pos == 0 && done == 0) ||
				(pos == 0 && $urandom_range(1, 0)) ||
				(noise && $urandom_range(40, 0) == 0);
			if (p.frame_start) pos = 0;
			pixel_queue = {pixel_queue, p};
			pos++;
			if (pos == w * h) begin
				pos = 0;
				done++;
			end
		end
	endtask

	initial begin
		int k, w, h, base;
		errors    = 0;
		cycles    = 0;
		sent      = 0;
		hold_req  = 0;
		col_cnt   = 0;
		row_cnt   = 0;
		cfg_k     = RST_WINDOW_SIZE;
		cfg_w     = RST_IMAGE_WIDTH;
		cfg_h     = RST_IMAGE_HEIGHT;
		for (int d = 0; d < MK - 1; d++)
			for (int c = 0; c < MW; c++) lstore[d][c] = '0;
		for (int y = 0; y < MK; y++)
			for (int x = 0; x < MK; x++) wnd[y][x] = '0;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: small 3x3 over a 5x4 frame, channel extremes
		set_size(3, 5, 4);
		queue_pixels(5, 4, 1, 0);
		// window as large as the frame, then larger than the frame
		set_size(5, 5, 5);
		queue_pixels(5, 5, 1, 0);
		set_size(5, 3, 4);
		queue_pixels(3, 4, 2, 0);
		// out-of-range window sizes and zero sizes
		set_size(0, 0, 0);
		queue_pixels(1, 1, 3, 0);
		set_size(7, 6, 6);
		queue_pixels(6, 6, 1, 0);
		set_size(6, 5, 5);
		queue_pixels(5, 5, 1, 0);
		// even window gives the upper median
		set_size(2, 4, 3);
		queue_pixels(4, 3, 2, 0);

		// random phases, mostly well-formed frames
		base = sent + pixel_queue.size();
		while (sent + pixel_queue.size() - base < N_RAND) begin
			k = ($urandom_range(9, 0) == 0) ? $urandom_range(7, 0) : $urandom_range(5, 1);
			w = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 0) : $urandom_range(12, 1);
			h = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 0) : $urandom_range(8, 1);
			set_size(k, w, h);
			// long receiver hold while the sender keeps going
			if ($urandom_range(7, 0) == 0) hold_req++;
			queue_pixels(w, h, $urandom_range(3, 1), $urandom_range(3, 0) == 0);
		end
		// one guaranteed long hold with a full stream behind it
		set_size(3, 10, 10);
		hold_req++;
		queue_pixels(10, 10, 1, 0);
		drain();

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
